>>> design/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// shared types, constants and helpers of the periodic timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int PERIOD_BITS_DEF = 24;

    localparam int KIND_W   = 2;
    localparam int PERIOD_W = 24;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 32;

    localparam logic [TIME_W-1:0] NEVER_EXPIRES = 32'h7FFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_POLL   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOTHING   = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic tick;
        logic reject;
        logic free_step;
        logic ins_write;
        logic scan_run;
        logic scan_finish;
        logic publish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  handle_bad;
        logic  free_hit;
        logic  scan_done;
        logic  out_free;
    } t_stat;

    // wrap-aware order of two expiries
    function automatic logic is_earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

>>> design/ptt_in_if.sv
// ----------------------------------------------------------------------------
// ptt_in_if
// input channel of the timer table: one command per transfer
// ----------------------------------------------------------------------------
interface ptt_in_if;

    logic                                 valid;
    logic                                 ready;
    ptt_pkg::t_kind                       kind;
    logic [ptt_pkg::PERIOD_W-1:0]         period;
    logic [ptt_pkg::HANDLE_W-1:0]         handle;

    modport source (output valid, kind, period, handle, input ready);
    modport sink   (input valid, kind, period, handle, output ready);

endinterface

>>> design/ptt_out_if.sv
// ----------------------------------------------------------------------------
// ptt_out_if
// result channel of the timer table: one result per transfer
// ----------------------------------------------------------------------------
interface ptt_out_if;

    logic                                 valid;
    logic                                 ready;
    ptt_pkg::t_status                     status;
    logic [ptt_pkg::HANDLE_W-1:0]         timer_handle;
    logic signed [ptt_pkg::TIME_W-1:0]    time_to_earliest;
    logic                                 table_empty;

    modport source (output valid, status, timer_handle, time_to_earliest, table_empty,
                    input ready);
    modport sink   (input valid, status, timer_handle, time_to_earliest, table_empty,
                    output ready);

endinterface

>>> design/periodic_timer_table_unit.sv
// operation: tick steps the clock; insert searches for a free slot, one slot a cycle;
//   remove and poll scan the order list, one entry a cycle, through a 3-stage pipe;
//   a rejected insert or remove goes to its result without a search or scan
// throughput: one item at a time; the next item is taken once the result is registered,
//   even while that result still waits for its transfer
// reset: synchronous active-low, clears clock, count, earliest and active bits; no clearing pass
// ----------------------------------------------------------------------------
// periodic_timer_table_unit
// table of periodic timers with tick, insert, remove and poll commands
// ----------------------------------------------------------------------------
module periodic_timer_table_unit #(
    parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
    parameter int PERIOD_BITS = ptt_pkg::PERIOD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_out_if.source o_out
);

    ptt_pkg::t_cmd  w_cmd;
    ptt_pkg::t_stat w_stat;

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ptt_dpath #(
        .SLOTS       (SLOTS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_kind             (i_in.kind),
        .i_period           (i_in.period),
        .i_handle           (i_in.handle),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_status           (o_out.status),
        .o_timer_handle     (o_out.timer_handle),
        .o_time_to_earliest (o_out.time_to_earliest),
        .o_table_empty      (o_out.table_empty)
    );

endmodule

>>> design/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// command sequencer: dispatches each item and steps the datapath scans
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptt_pkg::t_stat i_stat,
    output ptt_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_FREE     = 5'b00100,
        S_SCAN     = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    ptt_pkg::KIND_TICK: begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_DONE;
                    end
                    ptt_pkg::KIND_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FREE;
                        end
                    end
                    ptt_pkg::KIND_REMOVE: begin
                        if (i_stat.handle_bad) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    ptt_pkg::KIND_POLL: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FREE: begin
                if (i_stat.free_hit) begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.free_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.scan_run = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ptt_dpath.sv
// ----------------------------------------------------------------------------
// ptt_dpath
// timer state, slot memories, scan pipeline and result register
// ----------------------------------------------------------------------------
module ptt_dpath #(
    parameter int SLOTS       = ptt_pkg::SLOTS_DEF,
    parameter int PERIOD_BITS = ptt_pkg::PERIOD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ptt_pkg::t_cmd                        i_cmd,
    output ptt_pkg::t_stat                       o_stat,
    input  ptt_pkg::t_kind                       i_kind,
    input  logic [ptt_pkg::PERIOD_W-1:0]         i_period,
    input  logic [ptt_pkg::HANDLE_W-1:0]         i_handle,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output ptt_pkg::t_status                     o_status,
    output logic [ptt_pkg::HANDLE_W-1:0]         o_timer_handle,
    output logic signed [ptt_pkg::TIME_W-1:0]    o_time_to_earliest,
    output logic                                 o_table_empty
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = ptt_pkg::TIME_W;

    // slot memories
    logic [PERIOD_BITS-1:0] m_period [SLOTS];
    logic [TW-1:0]          m_expiry [SLOTS];
    logic [SW-1:0]          m_order  [SLOTS];

    // timer state
    logic [TW-1:0]          r_now;
    logic [CW-1:0]          r_count;
    logic [TW-1:0]          r_earliest;
    logic [SLOTS-1:0]       r_active;

    // current item
    ptt_pkg::t_kind         r_kind;
    logic [PERIOD_BITS-1:0] r_period;
    logic [ptt_pkg::HANDLE_W-1:0] r_handle;
    ptt_pkg::t_status       r_status;
    logic [ptt_pkg::HANDLE_W-1:0] r_th;

    // scan pipeline
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_j;
    logic                   r_first;
    logic                   r_found;
    logic [TW-1:0]          r_best;
    logic                   r_s1_vld;
    logic [SW-1:0]          r_ord_rd;
    logic                   r_s2_vld;
    logic                   r_s2_skip;
    logic [SW-1:0]          r_s2_slot;
    logic [TW-1:0]          r_exp_rd;
    logic [PERIOD_BITS-1:0] r_per_rd;
    logic                   r_s3_vld;
    logic [TW-1:0]          r_s3_e;

    // result register
    logic                   r_out_vld;
    ptt_pkg::t_status       r_out_status;
    logic [ptt_pkg::HANDLE_W-1:0] r_out_th;
    logic [TW-1:0]          r_out_tte;
    logic                   r_out_empty;

    logic [SW-1:0]          w_hslot;
    logic [SW-1:0]          w_free_slot;
    logic                   w_is_remove;
    logic                   w_is_poll;
    logic                   w_issue;
    logic                   w_keep;
    logic [TW-1:0]          w_ins_exp;
    logic [TW-1:0]          w_diff;
    logic [TW-1:0]          w_reload;
    logic                   w_expired;
    logic                   w_s2_hit;
    logic                   w_exp_we;
    logic [SW-1:0]          w_exp_wa;
    logic [TW-1:0]          w_exp_wd;
    logic                   w_ord_we;
    logic [SW-1:0]          w_ord_wa;
    logic [SW-1:0]          w_ord_wd;

    assign w_hslot     = SW'(r_handle);
    assign w_free_slot = r_idx[SW-1:0];
    assign w_is_remove = (r_kind == ptt_pkg::KIND_REMOVE);
    assign w_is_poll   = (r_kind == ptt_pkg::KIND_POLL);
    assign w_issue     = i_cmd.scan_run && (r_idx < r_count);
    assign w_keep      = r_s1_vld && !(w_is_remove && (r_ord_rd == w_hslot));
    assign w_ins_exp   = r_now + TW'(r_period);
    assign w_diff      = r_exp_rd - r_now;
    assign w_reload    = r_now + TW'(r_per_rd);
    assign w_expired   = w_is_poll && !r_found && ((w_diff == '0) || w_diff[TW-1]);
    assign w_s2_hit    = i_cmd.scan_run && r_s2_vld && !r_s2_skip && w_expired;

    assign o_stat.kind       = r_kind;
    assign o_stat.full       = (r_count >= CW'(SLOTS));
    assign o_stat.handle_bad = (32'(r_handle) >= 32'(SLOTS)) || !r_active[w_hslot];
    assign o_stat.free_hit   = !r_active[w_free_slot];
    assign o_stat.scan_done  = (r_idx >= r_count) && !r_s1_vld && !r_s2_vld && !r_s3_vld;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    // write port selection
    always_comb begin
        w_exp_we = 1'b0;
        w_exp_wa = w_free_slot;
        w_exp_wd = w_ins_exp;
        w_ord_we = 1'b0;
        w_ord_wa = r_count[SW-1:0];
        w_ord_wd = w_free_slot;
        if (i_cmd.ins_write) begin
            w_exp_we = 1'b1;
            w_ord_we = 1'b1;
        end else begin
            if (w_s2_hit) begin
                w_exp_we = 1'b1;
                w_exp_wa = r_s2_slot;
                w_exp_wd = w_reload;
            end
            if (i_cmd.scan_run && w_is_remove && w_keep) begin
                w_ord_we = 1'b1;
                w_ord_wa = r_j[SW-1:0];
                w_ord_wd = r_ord_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            m_period[w_free_slot] <= r_period;
        end
        if (w_exp_we) begin
            m_expiry[w_exp_wa] <= w_exp_wd;
        end
        if (w_ord_we) begin
            m_order[w_ord_wa] <= w_ord_wd;
        end
        r_ord_rd <= m_order[r_idx[SW-1:0]];
        r_exp_rd <= m_expiry[r_ord_rd];
        r_per_rd <= m_period[r_ord_rd];
    end

    // item registers and scan payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_period <= PERIOD_BITS'(i_period);
            r_handle <= i_handle;
            r_status <= ptt_pkg::ST_OK;
            r_th     <= '0;
            r_idx    <= '0;
            r_j      <= '0;
        end else begin
            if (i_cmd.reject) begin
                r_status <= w_is_remove ? ptt_pkg::ST_NOT_FOUND : ptt_pkg::ST_FULL;
            end
            if (i_cmd.free_step || w_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.ins_write) begin
                r_th <= ptt_pkg::HANDLE_W'(w_free_slot);
            end
            if (i_cmd.scan_run && w_is_remove && w_keep) begin
                r_j <= r_j + CW'(1);
            end
            if (w_s2_hit) begin
                r_th <= ptt_pkg::HANDLE_W'(r_s2_slot);
            end
            if (i_cmd.scan_finish && w_is_poll && !r_found) begin
                r_status <= ptt_pkg::ST_NOTHING;
            end
        end
        r_s2_slot <= r_ord_rd;
        r_s2_skip <= w_is_remove && (r_ord_rd == w_hslot);
        r_s3_e    <= w_expired ? w_reload : r_exp_rd;
    end

    // scan control and minimum tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_first  <= 1'b1;
            r_found  <= 1'b0;
        end else if (i_cmd.load) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_first  <= 1'b1;
            r_found  <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_s1_vld <= w_issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && !r_s2_skip;
            if (w_s2_hit) begin
                r_found <= 1'b1;
            end
            if (r_s3_vld) begin
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_run && r_s3_vld) begin
            if (r_first || ptt_pkg::is_earlier(r_s3_e, r_best)) begin
                r_best <= r_s3_e;
            end
        end
    end

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now      <= '0;
            r_count    <= '0;
            r_earliest <= '0;
            r_active   <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_now <= r_now + TW'(1);
            end
            if (i_cmd.ins_write) begin
                r_active[w_free_slot] <= 1'b1;
                r_count               <= r_count + CW'(1);
                if ((r_count == '0) || ptt_pkg::is_earlier(w_ins_exp, r_earliest)) begin
                    r_earliest <= w_ins_exp;
                end
            end
            if (i_cmd.scan_finish) begin
                if (w_is_remove) begin
                    r_active[w_hslot] <= 1'b0;
                    r_count           <= r_j;
                    r_earliest        <= r_first ? '0 : r_best;
                end else if (r_found) begin
                    r_earliest <= r_best;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_status <= r_status;
            r_out_th     <= r_th;
            r_out_empty  <= (r_count == '0);
            r_out_tte    <= (r_count == '0) ? ptt_pkg::NEVER_EXPIRES : (r_earliest - r_now);
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_status           = r_out_status;
    assign o_timer_handle     = r_out_th;
    assign o_time_to_earliest = r_out_tte;
    assign o_table_empty      = r_out_empty;

endmodule

>>> design/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks of the timer table, bound to the top level
// ----------------------------------------------------------------------------
module ptt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input ptt_pkg::t_status                  i_status,
    input logic [ptt_pkg::HANDLE_W-1:0]      i_timer_handle,
    input logic signed [ptt_pkg::TIME_W-1:0] i_tte,
    input logic                              i_table_empty
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second transfer taken while an item is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_timer_handle) && $stable(i_tte)))
        else $error("stalled result changed");

    a_empty_never: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_table_empty) |-> (i_tte == $signed(ptt_pkg::NEVER_EXPIRES)))
        else $error("empty table with finite earliest");

    a_error_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ptt_pkg::ST_OK)) |-> (i_timer_handle == '0))
        else $error("handle reported with error status");

endmodule

bind periodic_timer_table_unit ptt_checker u_ptt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_timer_handle (o_out.timer_handle),
    .i_tte          (o_out.time_to_earliest),
    .i_table_empty  (o_out.table_empty)
);
